[hdl/bba_pkg.sv]
// Shared types and constants for the bitmap block allocator.
`default_nettype none
package bba_pkg;

  // Bitmap geometry: 32-bit words, MSB of a word is its lowest block
  localparam int unsigned MAP_BITS  = 65536;
  localparam int unsigned MAP_BYTES = MAP_BITS / 8;
  localparam int unsigned MAP_WORDS = MAP_BITS / 32;
  localparam int unsigned WA_W      = $clog2(MAP_WORDS);

  // Field widths
  localparam int unsigned BLK_W   = 17;  // alloc base, block total, block limit
  localparam int unsigned CNT_W   = 32;  // free count and net allocation count
  localparam int unsigned IDX_W   = 16;  // block_index and block_number
  localparam int unsigned ADDR_W  = 13;  // map_byte_address
  localparam int unsigned CFG_W   = 32;  // config write data
  localparam int unsigned CFGI_W  = 2;   // config register index

  localparam logic [31:0] WORD_MSB = 32'h8000_0000;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_LOAD  = 2'd2,
    MODE_RSVD  = 2'd3
  } bba_mode_t;

  typedef enum logic [1:0] {
    RES_OK            = 2'd0,
    RES_NO_SPACE      = 2'd1,
    RES_OUT_OF_RANGE  = 2'd2,
    RES_ALREADY_CLEAR = 2'd3
  } bba_status_t;

  typedef enum logic [CFGI_W-1:0] {
    CFG_DATA_START    = 2'd0,
    CFG_TOTAL_BLOCKS  = 2'd1,
    CFG_INIT_FREE     = 2'd2,
    CFG_UNUSED        = 2'd3
  } bba_cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR  = 3'd0,
    S_IDLE   = 3'd1,
    S_DECODE = 3'd2,
    S_EVAL   = 3'd3,
    S_FINISH = 3'd4
  } bba_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;   // write zero to the current word during the clearing pass
    logic accept;   // capture the input transaction
    logic decode;   // pick start word, preset early result
    logic eval;     // act on the word just read
    logic advance;  // step to the next word
    logic finish;   // move the result into the output register
  } bba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;    // clearing pass is on the last word
    logic early_done;  // result is known without a bitmap access
    logic is_alloc;
    logic found;       // free bit found in the current word
    logic last_word;   // current word is the last one in the alloc range
    logic out_ready;   // output register can take a result
  } bba_sts_t;

endpackage
`default_nettype wire

[hdl/bba_ctrl.sv]
// Controller state machine for the bitmap block allocator.
`default_nettype none
module bba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bba_pkg::bba_sts_t sts,
  output bba_pkg::bba_cmd_t      cmd
);
  import bba_pkg::*;

  bba_state_t state_r, state_nxt;
  logic       scan_more;

  // Alloc keeps scanning while no free bit is found and words remain
  assign scan_more = sts.is_alloc && !sts.found && !sts.last_word;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:  if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: state_nxt = sts.early_done ? S_FINISH : S_EVAL;
      S_EVAL:   if (!scan_more) state_nxt = S_FINISH;
      S_FINISH: if (sts.out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd         = '0;
    cmd.clr_wr  = (state_r == S_CLEAR);
    cmd.advance = (state_r == S_CLEAR) || ((state_r == S_EVAL) && scan_more);
    cmd.accept  = (state_r == S_IDLE) && in_valid;
    cmd.decode  = (state_r == S_DECODE);
    cmd.eval    = (state_r == S_EVAL);
    cmd.finish  = (state_r == S_FINISH) && sts.out_ready;
    in_stall    = (state_r != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/bba_datapath.sv]
// Datapath: config registers, bitmap memory, word scan logic and output register.
`default_nettype none
module bba_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration
  input  wire logic                         cfg_wr_en,
  input  wire logic [bba_pkg::CFGI_W-1:0]   cfg_index,
  input  wire logic [bba_pkg::CFG_W-1:0]    cfg_data,
  // input payload
  input  wire logic [1:0]                   in_mode,
  input  wire logic [bba_pkg::IDX_W-1:0]    in_block_index,
  input  wire logic [bba_pkg::ADDR_W-1:0]   in_map_byte_address,
  input  wire logic [7:0]                   in_map_byte,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_status,
  output logic [bba_pkg::IDX_W-1:0]         out_block_number,
  output logic [bba_pkg::CNT_W-1:0]         out_free_count,
  // control
  input  wire bba_pkg::bba_cmd_t            cmd,
  output bba_pkg::bba_sts_t                 sts
);
  import bba_pkg::*;

  // Config and count registers
  logic [BLK_W-1:0]  alloc_base_r, blk_total_r;
  logic [CNT_W-1:0]  init_free_r, net_r;

  // Captured transaction
  bba_mode_t         mode_r;
  logic [IDX_W-1:0]  blk_r;
  logic [ADDR_W-1:0] addr_r;
  logic [7:0]        byte_r;

  // Scan state and memory
  logic [WA_W-1:0]   word_r, word_nxt;
  logic [31:0]       mem [MAP_WORDS];
  logic [31:0]       rd_data_r;
  logic              mem_we;
  logic [31:0]       mem_wdata;

  // Pending result
  bba_status_t       res_status_r;
  logic [IDX_W-1:0]  res_number_r;

  // Output register
  logic              out_valid_r;
  bba_status_t       out_status_r;
  logic [IDX_W-1:0]  out_number_r;
  logic [CNT_W-1:0]  out_count_r;

  // Derived limits
  logic [BLK_W-1:0]  limit, last_blk;
  logic [WA_W-1:0]   ds_word, last_word_idx, blk_word, addr_word;
  logic              empty_range, free_oor, load_oor;
  bba_status_t       early_status;

  // Word evaluation
  logic [4:0]        lo_j, hi_j, pos;
  logic [31:0]       avail;
  logic              found;
  logic [31:0]       alloc_word, free_word, load_word, pos_mask, blk_mask;
  logic              free_bit;
  logic [31:0]       n32;

  // Effective block limit, clamped to the map size
  assign limit    = (32'(blk_total_r) > MAP_BITS) ? BLK_W'(MAP_BITS) : blk_total_r;
  assign last_blk = limit - BLK_W'(1);

  assign ds_word       = WA_W'(32'(alloc_base_r) >> 5);
  assign last_word_idx = WA_W'(32'(last_blk) >> 5);
  assign blk_word      = WA_W'(32'(blk_r) >> 5);
  assign addr_word     = WA_W'(32'(addr_r) >> 2);

  // Cases settled without touching the bitmap
  assign empty_range = (alloc_base_r >= limit);
  assign free_oor    = (blk_r == '0) || (BLK_W'(blk_r) >= limit);
  assign load_oor    = !(32'(addr_r) < MAP_BYTES);

  always_comb begin
    case (mode_r)
      MODE_ALLOC: early_status = empty_range ? RES_NO_SPACE : RES_OK;
      MODE_FREE:  early_status = free_oor ? RES_OUT_OF_RANGE : RES_OK;
      default:    early_status = RES_OK;
    endcase
  end

  // Allowed bit window inside the current word
  assign lo_j = (word_r == ds_word) ? alloc_base_r[4:0] : 5'd0;
  assign hi_j = (word_r == last_word_idx) ? last_blk[4:0] : 5'd31;

  // Lowest clear bit in the window (bit j sits at word position 31-j)
  always_comb begin
    for (int j = 0; j < 32; j++) begin
      avail[j] = !rd_data_r[31-j] && (5'(j) >= lo_j) && (5'(j) <= hi_j);
    end
    pos = 5'd0;
    for (int j = 31; j >= 0; j--) begin
      if (avail[j]) pos = 5'(j);
    end
  end
  assign found = |avail;

  assign pos_mask   = WORD_MSB >> pos;
  assign alloc_word = rd_data_r | pos_mask;
  assign n32        = (32'(word_r) << 5) | 32'(pos);

  assign blk_mask  = WORD_MSB >> blk_r[4:0];
  assign free_bit  = |(rd_data_r & blk_mask);
  assign free_word = rd_data_r & ~blk_mask;

  // Byte lane replace for load
  always_comb begin
    load_word = rd_data_r;
    for (int l = 0; l < 4; l++) begin
      if (addr_r[1:0] == 2'(l)) load_word[31-8*l -: 8] = byte_r;
    end
  end

  // Memory write select
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    if (cmd.clr_wr) begin
      mem_we = 1'b1;
    end else if (cmd.eval) begin
      case (mode_r)
        MODE_ALLOC: begin
          mem_we    = found;
          mem_wdata = alloc_word;
        end
        MODE_FREE: begin
          mem_we    = free_bit;
          mem_wdata = free_word;
        end
        MODE_LOAD: begin
          mem_we    = 1'b1;
          mem_wdata = load_word;
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  // Word pointer: clear counter, start word, scan step
  always_comb begin
    word_nxt = word_r;
    if (cmd.advance) begin
      word_nxt = word_r + WA_W'(1);
    end else if (cmd.decode) begin
      case (mode_r)
        MODE_ALLOC: word_nxt = ds_word;
        MODE_FREE:  word_nxt = blk_word;
        MODE_LOAD:  word_nxt = addr_word;
        default:    word_nxt = word_r;
      endcase
    end
  end

  // Bitmap memory, registered read of the next word
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[word_r] <= mem_wdata;
    end
    rd_data_r <= mem[word_nxt];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r         <= '0;
      alloc_base_r   <= '0;
      blk_total_r    <= BLK_W'(65536);
      init_free_r    <= '0;
      net_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      word_r <= word_nxt;
      if (cfg_wr_en) begin
        case (bba_cfg_idx_t'(cfg_index))
          CFG_DATA_START:   alloc_base_r   <= cfg_data[BLK_W-1:0];
          CFG_TOTAL_BLOCKS: blk_total_r    <= cfg_data[BLK_W-1:0];
          CFG_INIT_FREE:    init_free_r    <= cfg_data[CNT_W-1:0];
          default:          ;
        endcase
      end
      if (cmd.eval && (mode_r == MODE_ALLOC) && found) begin
        net_r <= net_r + CNT_W'(1);
      end else if (cmd.eval && (mode_r == MODE_FREE) && free_bit) begin
        net_r <= net_r - CNT_W'(1);
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= bba_mode_t'(in_mode);
      blk_r  <= in_block_index;
      addr_r <= in_map_byte_address;
      byte_r <= in_map_byte;
    end
    if (cmd.decode) begin
      res_status_r <= early_status;
      res_number_r <= '0;
    end else if (cmd.eval) begin
      case (mode_r)
        MODE_ALLOC: begin
          if (found) begin
            res_status_r <= RES_OK;
            res_number_r <= n32[IDX_W-1:0];
          end else if (word_r == last_word_idx) begin
            res_status_r <= RES_NO_SPACE;
          end
        end
        MODE_FREE: res_status_r <= free_bit ? RES_OK : RES_ALREADY_CLEAR;
        default:   res_status_r <= RES_OK;
      endcase
    end
    if (cmd.finish) begin
      out_status_r <= res_status_r;
      out_number_r <= res_number_r;
      out_count_r  <= init_free_r - net_r;
    end
  end

  // Status to controller
  always_comb begin
    sts            = '0;
    sts.clr_last   = (32'(word_r) == MAP_WORDS - 1);
    sts.early_done = (mode_r == MODE_RSVD) ||
                     ((mode_r == MODE_ALLOC) && empty_range) ||
                     ((mode_r == MODE_FREE) && free_oor) ||
                     ((mode_r == MODE_LOAD) && load_oor);
    sts.is_alloc   = (mode_r == MODE_ALLOC);
    sts.found      = found;
    sts.last_word  = (word_r == last_word_idx);
    sts.out_ready  = !out_valid_r || !out_stall;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_block_number = out_number_r;
  assign out_free_count   = out_count_r;

endmodule
`default_nettype wire

[hdl/bitmap_block_allocator.sv]
// Top level: first-fit bitmap block allocator, controller plus datapath.
// Accept to out_valid: free and load pass DECODE, EVAL and FINISH; range rejects and mode 3
// skip EVAL. Alloc repeats EVAL once per 32-bit bitmap word scanned (1 to 2048 words).
// Throughput: one transaction at a time; the next accept can come in the cycle out_valid
// rises, and a stalled result holds the controller in FINISH. Reset: synchronous, active
// low; a clearing pass then zeroes the bitmap with in_stall high (config taken).
`default_nettype none
module bitmap_block_allocator (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration
  input  wire logic                         cfg_wr_en,
  input  wire logic [bba_pkg::CFGI_W-1:0]   cfg_index,
  input  wire logic [bba_pkg::CFG_W-1:0]    cfg_data,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_mode,
  input  wire logic [bba_pkg::IDX_W-1:0]    in_block_index,
  input  wire logic [bba_pkg::ADDR_W-1:0]   in_map_byte_address,
  input  wire logic [7:0]                   in_map_byte,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_status,
  output logic [bba_pkg::IDX_W-1:0]         out_block_number,
  output logic [bba_pkg::CNT_W-1:0]         out_free_count
);
  import bba_pkg::*;

  bba_cmd_t cmd;
  bba_sts_t sts;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bba_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_mode             (in_mode),
    .in_block_index      (in_block_index),
    .in_map_byte_address (in_map_byte_address),
    .in_map_byte         (in_map_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_block_number    (out_block_number),
    .out_free_count      (out_free_count),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule
`default_nettype wire
